// ===== design/pse_pkg.sv =====
// Package for the positional stack engine.
// Holds sizes, command and status codes, and the control bundle that the
// top level broadcasts to every stack cell. Depends on nothing.
package pse_pkg;

    localparam int DEPTH   = 64;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int WORD_W  = 32;
    localparam int CMD_W   = 3;
    localparam int POS_W   = 7;
    localparam int STAT_W  = 2;
    localparam int TOTAL_W = 7;

    localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SORT   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_PUSH,
        OP_INS,
        OP_DEL,
        OP_SORT
    } t_cell_op;

    typedef struct packed {
        t_cell_op                 op;
        logic [IDX_W-1:0]         sel;
        logic signed [WORD_W-1:0] val;
        logic                     phase;
        logic [CNT_W-1:0]         cnt;
    } t_cell_ctl;

endpackage

// ===== design/pse_cell.sv =====
// One storage cell of the positional stack engine.
// Holds one word and moves it to or from its neighbors on the broadcast
// command; also does one compare-exchange step of the sort. Uses pse_pkg.
module pse_cell (
    input  logic                              i_clk,
    input  logic [pse_pkg::IDX_W-1:0]         i_idx,
    input  pse_pkg::t_cell_ctl                i_ctl,
    input  logic signed [pse_pkg::WORD_W-1:0] i_below,
    input  logic signed [pse_pkg::WORD_W-1:0] i_above,
    output logic signed [pse_pkg::WORD_W-1:0] o_word,
    output logic signed [pse_pkg::WORD_W-1:0] o_pick
);

    logic signed [pse_pkg::WORD_W-1:0] r_word;
    logic signed [pse_pkg::WORD_W-1:0] n_word;
    logic                              w_hit;
    logic                              w_lower;
    logic                              w_upper;

    assign w_hit = (i_idx == i_ctl.sel);

    // The cell pairs with the cell above on one phase and the cell below on the other.
    assign w_lower = (i_idx[0] == i_ctl.phase)
                  && ((pse_pkg::CNT_W'(i_idx) + pse_pkg::CNT_W'(1)) < i_ctl.cnt)
                  && (r_word < i_above);
    assign w_upper = (i_idx[0] != i_ctl.phase)
                  && (i_idx != '0)
                  && (pse_pkg::CNT_W'(i_idx) < i_ctl.cnt)
                  && (i_below < r_word);

    always_comb begin
        n_word = r_word;
        unique case (i_ctl.op)
            pse_pkg::OP_HOLD: begin
                n_word = r_word;
            end
            pse_pkg::OP_PUSH: begin
                if (w_hit) n_word = i_ctl.val;
            end
            pse_pkg::OP_INS: begin
                if (w_hit) begin
                    n_word = i_ctl.val;
                end else if (i_idx > i_ctl.sel) begin
                    n_word = i_below;
                end
            end
            pse_pkg::OP_DEL: begin
                if (i_idx >= i_ctl.sel) n_word = i_above;
            end
            pse_pkg::OP_SORT: begin
                if (w_lower) begin
                    n_word = i_above;
                end else if (w_upper) begin
                    n_word = i_below;
                end
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;
    assign o_pick = w_hit ? r_word : '0;

endmodule

// ===== design/positional_stack_engine.sv =====
// Top level of the positional stack engine: command decode, count and sort
// sequencer, and the chain of pse_cell storage cells. Uses pse_pkg.
//
// Usage: a command beat is taken at a rising edge where start is high and
// busy is low. It carries i_cmd, i_value and i_position (1 at the bottom).
// Push, pop, insert, delete and unknown commands finish in one cycle: the
// result appears on the next cycle with o_valid high for exactly one cycle,
// and a new command may be taken in that same cycle.
// Sort on two or more words runs odd-even transposition passes through the
// cell chain, one pass per cycle, DEPTH passes in all; busy is high for
// all of those passes and the result follows right after the last pass.
// So the rate is one command per cycle while busy is low; sort holds busy
// high through its exchange passes over the chain.
// Each result carries status, the popped or deleted word (zero otherwise)
// and the word count after the command. Failed commands change nothing.
// The receiver cannot stall: every result beat is taken when shown.
// Reset (synchronous, active low) empties the stack and clears busy and
// o_valid; stored words keep stale contents that are never read.
module positional_stack_engine (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [pse_pkg::CMD_W-1:0]          i_cmd,
    input  logic signed [pse_pkg::WORD_W-1:0]  i_value,
    input  logic [pse_pkg::POS_W-1:0]          i_position,
    output logic                               o_valid,
    output logic [pse_pkg::STAT_W-1:0]         o_status,
    output logic signed [pse_pkg::WORD_W-1:0]  o_data_out,
    output logic [pse_pkg::TOTAL_W-1:0]        o_entry_total
);

    typedef enum logic {
        S_IDLE,
        S_SORT
    } t_state;

    t_state                            r_state;
    logic [pse_pkg::CNT_W-1:0]         r_cnt;
    logic [pse_pkg::IDX_W-1:0]         r_pass;
    logic                              r_valid;
    logic [pse_pkg::STAT_W-1:0]        r_status;
    logic signed [pse_pkg::WORD_W-1:0] r_data;
    logic [pse_pkg::TOTAL_W-1:0]       r_total;

    pse_pkg::t_cell_ctl                w_ctl;
    logic [pse_pkg::STAT_W-1:0]        w_status;
    logic [pse_pkg::CNT_W-1:0]         w_cnt_next;
    logic                              w_take;
    logic                              w_sort;
    logic                              w_full;
    logic                              w_pos_bad;
    logic signed [pse_pkg::WORD_W-1:0] w_pick;

    logic signed [pse_pkg::WORD_W-1:0] w_words [pse_pkg::DEPTH];
    logic signed [pse_pkg::WORD_W-1:0] w_picks [pse_pkg::DEPTH];

    assign busy      = (r_state == S_SORT);
    assign w_full    = (r_cnt == pse_pkg::CNT_W'(pse_pkg::DEPTH));
    assign w_pos_bad = (i_position == '0) || (32'(i_position) > 32'(r_cnt));

    always_comb begin
        w_ctl.op    = pse_pkg::OP_HOLD;
        w_ctl.sel   = '0;
        w_ctl.val   = i_value;
        w_ctl.phase = r_pass[0];
        w_ctl.cnt   = r_cnt;
        w_status    = pse_pkg::ST_OK;
        w_cnt_next  = r_cnt;
        w_take      = 1'b0;
        w_sort      = 1'b0;
        if (r_state == S_SORT) begin
            w_ctl.op = pse_pkg::OP_SORT;
        end else if (start) begin
            unique case (i_cmd)
                pse_pkg::CMD_PUSH: begin
                    if (w_full) begin
                        w_status = pse_pkg::ST_FULL;
                    end else begin
                        w_ctl.op   = pse_pkg::OP_PUSH;
                        w_ctl.sel  = r_cnt[pse_pkg::IDX_W-1:0];
                        w_cnt_next = r_cnt + pse_pkg::CNT_W'(1);
                    end
                end
                pse_pkg::CMD_POP: begin
                    if (r_cnt == '0) begin
                        w_status = pse_pkg::ST_EMPTY;
                    end else begin
                        w_ctl.sel  = pse_pkg::IDX_W'(r_cnt - pse_pkg::CNT_W'(1));
                        w_take     = 1'b1;
                        w_cnt_next = r_cnt - pse_pkg::CNT_W'(1);
                    end
                end
                pse_pkg::CMD_INSERT: begin
                    if (w_full) begin
                        w_status = pse_pkg::ST_FULL;
                    end else if (w_pos_bad) begin
                        w_status = pse_pkg::ST_BADPOS;
                    end else begin
                        w_ctl.op   = pse_pkg::OP_INS;
                        w_ctl.sel  = pse_pkg::IDX_W'(i_position);
                        w_cnt_next = r_cnt + pse_pkg::CNT_W'(1);
                    end
                end
                pse_pkg::CMD_DELETE: begin
                    if (w_pos_bad) begin
                        w_status = pse_pkg::ST_BADPOS;
                    end else begin
                        w_ctl.op   = pse_pkg::OP_DEL;
                        w_ctl.sel  = pse_pkg::IDX_W'(i_position - pse_pkg::POS_W'(1));
                        w_take     = 1'b1;
                        w_cnt_next = r_cnt - pse_pkg::CNT_W'(1);
                    end
                end
                pse_pkg::CMD_SORT: begin
                    w_sort = (r_cnt > pse_pkg::CNT_W'(1));
                end
                default: begin
                    w_status = pse_pkg::ST_OK;
                end
            endcase
        end
    end

    for (genvar g = 0; g < pse_pkg::DEPTH; g++) begin : g_cell
        logic signed [pse_pkg::WORD_W-1:0] w_below;
        logic signed [pse_pkg::WORD_W-1:0] w_above;

        if (g == 0) begin : g_bottom
            assign w_below = '0;
        end else begin : g_mid_lo
            assign w_below = w_words[g-1];
        end

        if (g == pse_pkg::DEPTH - 1) begin : g_top
            assign w_above = '0;
        end else begin : g_mid_hi
            assign w_above = w_words[g+1];
        end

        pse_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (pse_pkg::IDX_W'(g)),
            .i_ctl   (w_ctl),
            .i_below (w_below),
            .i_above (w_above),
            .o_word  (w_words[g]),
            .o_pick  (w_picks[g])
        );
    end

    always_comb begin
        w_pick = '0;
        for (int j = 0; j < pse_pkg::DEPTH; j++) begin
            w_pick = w_pick | w_picks[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pass  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        if (w_sort) begin
                            r_state <= S_SORT;
                            r_pass  <= '0;
                        end else begin
                            r_valid  <= 1'b1;
                            r_status <= w_status;
                            r_data   <= w_take ? w_pick : '0;
                            r_total  <= pse_pkg::TOTAL_W'(w_cnt_next);
                            r_cnt    <= w_cnt_next;
                        end
                    end
                end
                S_SORT: begin
                    r_pass <= r_pass + pse_pkg::IDX_W'(1);
                    if (r_pass == pse_pkg::IDX_W'(pse_pkg::DEPTH - 1)) begin
                        r_state  <= S_IDLE;
                        r_valid  <= 1'b1;
                        r_status <= pse_pkg::ST_OK;
                        r_data   <= '0;
                        r_total  <= pse_pkg::TOTAL_W'(r_cnt);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_data_out    = r_data;
    assign o_entry_total = r_total;

endmodule

// ===== design/pse_checker.sv =====
// Port-level checker for the positional stack engine, bound to the top level.
// Watches command and result beats over time. Uses pse_pkg.
module pse_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic [pse_pkg::CMD_W-1:0]          i_cmd,
    input logic                               o_valid,
    input logic [pse_pkg::STAT_W-1:0]         o_status,
    input logic signed [pse_pkg::WORD_W-1:0]  o_data_out,
    input logic [pse_pkg::TOTAL_W-1:0]        o_entry_total
);

    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd != pse_pkg::CMD_SORT)) |=> o_valid)
        else $error("Single-cycle command gave no result beat.");

    a_no_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_valid)
        else $error("Result beat shown while sorting.");

    a_error_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != pse_pkg::ST_OK)) |-> (o_data_out == '0))
        else $error("Failed command returned a nonzero word.");

    a_count_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((32'(o_entry_total) <= 32'(pse_pkg::DEPTH))
            && ((o_status != pse_pkg::ST_EMPTY) || (o_entry_total == '0))
            && ((o_status != pse_pkg::ST_FULL)
                || (32'(o_entry_total) == 32'(pse_pkg::DEPTH)))))
        else $error("Word count disagrees with status.");

endmodule

bind positional_stack_engine pse_checker u_pse_checker (.*);
